FILE: sv/w512_pkg.sv
// Shared types and constants for the WELL512a generator.
`timescale 1ns / 1ps

package w512_pkg;

  localparam int unsigned POOL_WORDS = 16;
  localparam int unsigned IDX_W      = $clog2(POOL_WORDS);
  localparam int unsigned WORD_W     = 32;

  localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA442D24;

  // Commands from controller to datapath
  typedef struct packed {
    logic draw;       // run one draw step and load the output word
    logic seed_load;  // load the seed into pool word 0
    logic seed_step;  // compute the next pool word of the seed fill
  } w512_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fill_last;  // the current seed step writes the last pool word
  } w512_sts_t;

endpackage

FILE: sv/w512_ctrl.sv
// Controller for the WELL512a generator: handshakes and seed fill sequencing.
`timescale 1ns / 1ps

module w512_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output w512_pkg::w512_cmd_t cmd,
  input  w512_pkg::w512_sts_t sts
);
  import w512_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept;

  // Stall input during the fill, or while a finished word is still stalled
  assign in_stall  = (state_r == ST_FILL) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_req_type) begin
            cmd.draw = 1'b1;
          end else begin
            cmd.seed_load = 1'b1;
            state_nxt     = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.seed_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the output beat until taken, load it on a draw
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.draw) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> in_stall)
    else $error("input not stalled during seed fill");

  a_draw_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw |=> out_valid)
    else $error("draw did not raise output valid");

  a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && sts.fill_last) |=> (state_r == ST_IDLE))
    else $error("seed fill did not end after last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.draw)
    else $error("draw overwrote a stalled output beat");
`endif

endmodule

FILE: sv/w512_dpath.sv
// Datapath for the WELL512a generator: rotating pool, seed recurrence, output word.
`timescale 1ns / 1ps

module w512_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         in_seed_value,
  output logic [31:0]         out_random_word,
  input  w512_pkg::w512_cmd_t cmd,
  output w512_pkg::w512_sts_t sts
);
  import w512_pkg::*;

  // Pool kept rotated so that slot j holds the word at position + j
  logic [WORD_W-1:0] pool_r [POOL_WORDS];
  logic [WORD_W-1:0] prev_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [WORD_W-1:0] word_r;

  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] v0, vm1, vm2, z0;
  logic [WORD_W-1:0] z1, z2, nv1, nv0;

  function automatic logic [WORD_W-1:0] xsl(input logic [WORD_W-1:0] v,
                                            input int unsigned       t);
    xsl = v ^ (v << t);
  endfunction

  // Seed recurrence: next word from the previous one
  assign mix       = prev_r ^ (prev_r >> 30);
  assign prod      = SEED_MULT * mix;
  assign seed_word = prod + {{(WORD_W-IDX_W){1'b0}}, cnt_r};
  assign sts.fill_last = (cnt_r == IDX_W'(POOL_WORDS - 1));

  // Draw mix from fixed pool taps
  assign v0  = pool_r[0];
  assign vm1 = pool_r[13];
  assign vm2 = pool_r[9];
  assign z0  = pool_r[POOL_WORDS-1];
  assign z1  = xsl(v0, 16) ^ xsl(vm1, 15);
  assign z2  = vm2 ^ (vm2 >> 11);
  assign nv1 = z1 ^ z2;
  assign nv0 = xsl(z0, 2) ^ xsl(z1, 18) ^ (z2 << 28) ^ (nv1 ^ ((nv1 << 5) & TEMPER_MASK));

  // Update pool: rotate on a draw, fill slot by slot on a seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < POOL_WORDS; j++) begin
        pool_r[j] <= '0;
      end
      cnt_r <= '0;
    end else if (cmd.draw) begin
      pool_r[0] <= nv0;
      pool_r[1] <= nv1;
      for (int j = 2; j < POOL_WORDS; j++) begin
        pool_r[j] <= pool_r[j-1];
      end
    end else if (cmd.seed_load) begin
      pool_r[0] <= in_seed_value;
      cnt_r     <= IDX_W'(1);
    end else if (cmd.seed_step) begin
      pool_r[cnt_r] <= seed_word;
      cnt_r         <= cnt_r + IDX_W'(1);
    end
  end

  // Hold the previous seed word and the output word
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      prev_r <= in_seed_value;
    end else if (cmd.seed_step) begin
      prev_r <= seed_word;
    end
    if (cmd.draw) begin
      word_r <= nv0;
    end
  end

  assign out_random_word = word_r;

endmodule

FILE: sv/well512_random_generator.sv
// Top level of the WELL512a pseudo-random word generator.
`timescale 1ns / 1ps

// WELL512a generator with a sixteen-word pool. A draw beat (req_type 1) gives one
// registered 32-bit word; draws stream at one per cycle while the output
// side takes them, since the pool is held as a rotating register line with fixed
// taps and the result sits in an output register. A seed beat (req_type 0) gives
// no result and occupies the block while it loads the seed, then runs 15
// steps of the seed recurrence through a single 32x32 multiplier, one pool word
// per cycle; input is stalled meanwhile. After reset the pool is all zeros.
module well512_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_word
);
  import w512_pkg::*;

  w512_cmd_t cmd;
  w512_sts_t sts;

  w512_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  w512_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_seed_value   (in_seed_value),
    .out_random_word (out_random_word),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: sim/well512_random_generator_tb.sv
// Self-checking testbench for the WELL512a random word generator.
`timescale 1ns / 1ps

module well512_random_generator_tb;
  import w512_pkg::*;

  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_DRAW = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [31:0] seed;
  } gen_req_t;

  localparam int unsigned RANDOM_REQS = 1025;
  localparam int unsigned MAX_PRINTS  = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [31:0] in_seed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_random_word;

  // Generator state as predicted by the testbench
  logic [WORD_W-1:0] model_pool [POOL_WORDS];
  logic [IDX_W-1:0]  model_pos;

  gen_req_t          pending_reqs [$];
  logic [WORD_W-1:0] expected_words [$];

  int unsigned errors = 0;
  int unsigned n_seeds = 0;
  int unsigned n_draws = 0;
  int unsigned n_checked = 0;

  logic        in_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_run = 0;
  int unsigned stall_mode = 0;

  well512_random_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_seed_value  (in_seed_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_random_word(out_random_word)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [WORD_W-1:0] xor_shl(input logic [WORD_W-1:0] v,
                                                input int unsigned t);
    return v ^ (v << t);
  endfunction

  // Fill the pool from a seed by the multiplicative recurrence
  function automatic void seed_pool(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    model_pool[0] = seed;
    for (int unsigned k = 1; k < POOL_WORDS; k++) begin
      prev = model_pool[k-1];
      model_pool[k] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
    end
    model_pos = '0;
  endfunction

  // One draw step: mix four taps, write two words back, step the index
  function automatic logic [WORD_W-1:0] draw_word();
    logic [IDX_W-1:0]  p;
    logic [IDX_W-1:0]  tap13;
    logic [IDX_W-1:0]  tap9;
    logic [WORD_W-1:0] z0, z1, z2, nv0, nv1;
    p     = model_pos;
    tap13 = p + IDX_W'(13);
    tap9  = p + IDX_W'(9);
    z1    = xor_shl(model_pool[p], 16) ^ xor_shl(model_pool[tap13], 15);
    z2    = model_pool[tap9] ^ (model_pool[tap9] >> 11);
    nv1   = z1 ^ z2;
    model_pool[p] = nv1;
    p     = p + IDX_W'(15);
    model_pos = p;
    z0    = model_pool[p];
    nv0   = xor_shl(z0, 2) ^ xor_shl(z1, 18) ^ (z2 << 28)
          ^ (nv1 ^ ((nv1 << 5) & TEMPER_MASK));
    model_pool[p] = nv0;
    return nv0;
  endfunction

  function automatic void push_req(input req_kind_t kind, input logic [31:0] seed);
    gen_req_t r;
    r.kind = kind;
    r.seed = seed;
    pending_reqs.push_back(r);
  endfunction

  // Drive input beats in bursts with random gaps; hold the payload while stalled
  always @(negedge clk) begin
    gen_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_valid      <= 1'b1;
        in_req_type   <= r.kind;
        in_seed_value <= r.seed;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // leave some bursts back to back
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side on a pattern whose mode is redrawn when each random run ends
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(8, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_run % 3 == 0);
    endcase
  end

  // Check result beats against the oldest prediction, then predict new input beats
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %08h with no draw pending", out_random_word));
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        if (out_random_word !== want)
          report_mismatch($sformatf("random_word got %08h want %08h",
                                    out_random_word, want));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      if (in_req_type == REQ_DRAW) begin
        expected_words.push_back(draw_word());
        n_draws++;
      end else begin
        seed_pool(in_seed_value);
        n_seeds++;
      end
    end
  end

  initial begin
    int unsigned queued;
    int unsigned run_len;
    int unsigned drain;
    logic [31:0] s;

    for (int unsigned i = 0; i < POOL_WORDS; i++) model_pool[i] = '0;
    model_pos = '0;

    // Directed: draws from the zero pool, extreme seeds, a full index wrap
    push_req(REQ_DRAW, 32'h0000_0000);
    push_req(REQ_DRAW, 32'hFFFF_FFFF);
    push_req(REQ_SEED, 32'hFFFF_FFFF);
    for (int i = 0; i < 17; i++) push_req(REQ_DRAW, $urandom);
    push_req(REQ_SEED, 32'h0000_0000);
    push_req(REQ_DRAW, 32'hFFFF_FFFF);
    push_req(REQ_SEED, 32'h8000_0001);
    push_req(REQ_DRAW, 32'h0000_0000);

    // Random: mostly a reseed followed by a run of draws, some runs without a seed
    queued = 0;
    while (queued < RANDOM_REQS) begin
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 7))
          0:       s = 32'h0000_0000;
          1:       s = 32'hFFFF_FFFF;
          default: s = $urandom;
        endcase
        push_req(REQ_SEED, s);
        queued++;
      end
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      for (int unsigned i = 0; i < run_len; i++) push_req(REQ_DRAW, $urandom);
      queued += run_len;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all beats to be taken, then for the remaining words
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    drain = 0;
    while (expected_words.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    while (expected_words.size() != 0) begin
      report_mismatch($sformatf("word %08h never came out", expected_words.pop_front()));
    end

    $display("Covered %0d reseeds and %0d draws, %0d words compared.",
             n_seeds, n_draws, n_checked);
    $display("Zero pool, extreme seeds and index wrap hit; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("Timeout with %0d words still pending.", expected_words.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/w512_pkg.sv
sv/w512_ctrl.sv
sv/w512_dpath.sv
sv/well512_random_generator.sv
sim/well512_random_generator_tb.sv
